/* hdl/mi3_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_pkg
// Types and constants shared by the 3x3 matrix inverse pipeline.
// ----------------------------------------------------------------------------
package mi3_pkg;

   localparam int ENTRY_W = 32;
   localparam int PROD_W  = 64;   // entry by entry product
   localparam int ADJ_W   = 65;   // adjugate entry
   localparam int DP_W    = 65;   // entry by adjugate partial product
   localparam int DET_W   = 98;   // determinant, signed
   localparam int DEN_W   = 96;   // determinant magnitude
   localparam int Q_W     = 33;   // quotient bits below the overflow check

   typedef logic [3:0] idx_type;

   // minor operands per adjugate entry: p*q - r*s
   localparam idx_type ADJ_TAB [9][4] = '{
      '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
      '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
      '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
   };

   typedef struct packed {
      logic signed [ENTRY_W-1:0] a_00;
      logic signed [ENTRY_W-1:0] a_01;
      logic signed [ENTRY_W-1:0] a_02;
      logic signed [ENTRY_W-1:0] a_10;
      logic signed [ENTRY_W-1:0] a_11;
      logic signed [ENTRY_W-1:0] a_12;
      logic signed [ENTRY_W-1:0] a_20;
      logic signed [ENTRY_W-1:0] a_21;
      logic signed [ENTRY_W-1:0] a_22;
   } req_type;

   typedef struct packed {
      logic signed [ENTRY_W-1:0] inv_00;
      logic signed [ENTRY_W-1:0] inv_01;
      logic signed [ENTRY_W-1:0] inv_02;
      logic signed [ENTRY_W-1:0] inv_10;
      logic signed [ENTRY_W-1:0] inv_11;
      logic signed [ENTRY_W-1:0] inv_12;
      logic signed [ENTRY_W-1:0] inv_20;
      logic signed [ENTRY_W-1:0] inv_21;
      logic signed [ENTRY_W-1:0] inv_22;
      logic signed [ENTRY_W-1:0] recip_det;
      logic                      singular;
      logic                      saturated;
   } rsp_type;

endpackage

/* hdl/mi3_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_div
// Pipelined restoring divider: overflow check, then one quotient bit per
// stage, with signed saturation to 32 bits at the end.
// ----------------------------------------------------------------------------
module mi3_div
   import mi3_pkg::*;
#(
   parameter int NUM_W = 96
) (
   input  logic                      clock,
   input  logic                      enable,
   input  logic [NUM_W-1:0]          num,
   input  logic [DEN_W-1:0]          den,
   input  logic                      neg,
   output logic signed [ENTRY_W-1:0] quot,
   output logic                      sat
);

   localparam int CW = DEN_W + Q_W + 1;

   logic [CW-1:0]    rem_ff [Q_W];
   logic [DEN_W-1:0] den_ff [Q_W];
   logic [Q_W-1:0]   q_ff   [Q_W+1];
   logic             big_ff [Q_W+1];
   logic             neg_ff [Q_W+1];

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0] <= CW'(num);
         den_ff[0] <= den;
         q_ff[0]   <= '0;
         neg_ff[0] <= neg;
         big_ff[0] <= CW'(num) >= (CW'(den) << Q_W);
      end
   end

   for (genvar j = 0; j < Q_W; j++) begin : g_step
      localparam int B = Q_W - 1 - j;
      logic [CW-1:0] cand;
      logic          fit;
      assign cand = CW'(den_ff[j]) << B;
      assign fit  = !big_ff[j] && (rem_ff[j] >= cand);
      always_ff @(posedge clock) begin
         if (enable) begin
            q_ff[j+1]   <= {q_ff[j][Q_W-2:0], fit};
            big_ff[j+1] <= big_ff[j];
            neg_ff[j+1] <= neg_ff[j];
         end
      end
      if (j < Q_W - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (enable) begin
               rem_ff[j+1] <= fit ? rem_ff[j] - cand : rem_ff[j];
               den_ff[j+1] <= den_ff[j];
            end
         end
      end
   end

   logic [Q_W-1:0] q;
   logic           over;

   always_comb begin
      q = q_ff[Q_W];
      if (neg_ff[Q_W]) begin
         over = big_ff[Q_W] || q[Q_W-1] || (q[ENTRY_W-1] && (q[ENTRY_W-2:0] != '0));
         quot = over ? {1'b1, {(ENTRY_W-1){1'b0}}} : -$signed(q[ENTRY_W-1:0]);
      end else begin
         over = big_ff[Q_W] || q[Q_W-1] || q[ENTRY_W-1];
         quot = over ? {1'b0, {(ENTRY_W-1){1'b1}}} : $signed(q[ENTRY_W-1:0]);
      end
      sat = over;
   end

endmodule

/* hdl/matrix_inverse_3x3.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_inverse_3x3
// 3x3 fixed-point matrix inverse by adjugate and exact determinant.
// ----------------------------------------------------------------------------
// usage
//   req channel: one transaction carries the nine matrix entries, signed
//   fixed point with FRAC_BITS fraction bits
//   rsp channel: one transaction per request with the nine inverse entries,
//   the determinant reciprocal, singular and saturated flags
//   pipeline: 5 product/determinant stages, 34 divider stages and 1
//   output register between request and response
//   throughput: one matrix per cycle unless rsp_stall holds the response;
//   ten restoring dividers, one quotient bit per stage, run side by side
//   stall: when the response is held by rsp_stall the whole pipeline
//   freezes and req_stall is raised; nothing is dropped or repeated
//   reset: clears every valid bit, no response is pending afterwards
// ----------------------------------------------------------------------------
module matrix_inverse_3x3
   import mi3_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int NUM_W = PROD_W + 2 * FRAC_BITS;
   localparam int DLY   = Q_W + 1;

   logic adv;
   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   logic signed [ENTRY_W-1:0] a [9];
   assign a[0] = req_data.a_00;
   assign a[1] = req_data.a_01;
   assign a[2] = req_data.a_02;
   assign a[3] = req_data.a_10;
   assign a[4] = req_data.a_11;
   assign a[5] = req_data.a_12;
   assign a[6] = req_data.a_20;
   assign a[7] = req_data.a_21;
   assign a[8] = req_data.a_22;

   logic [4:0] v_ff;

   // stage 1: minor products
   logic signed [PROD_W-1:0]  pp_ff [9];
   logic signed [PROD_W-1:0]  pn_ff [9];
   logic signed [ENTRY_W-1:0] col1_ff [3];
   // stage 2: adjugate
   logic signed [ADJ_W-1:0]   adj2_ff [9];
   logic signed [ENTRY_W-1:0] col2_ff [3];
   // stage 3: determinant partial products
   logic signed [DP_W-1:0]    dlo_ff [3];
   logic signed [DP_W-1:0]    dhi_ff [3];
   logic signed [ADJ_W-1:0]   adj3_ff [9];
   // stage 4: determinant
   logic signed [DET_W-1:0]   det_ff;
   logic signed [ADJ_W-1:0]   adj4_ff [9];
   // stage 5: divider operands
   logic [NUM_W-1:0]          num_ff [10];
   logic                      neg_ff [10];
   logic [DEN_W-1:0]          den_ff;
   logic                      sing5_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 9; i++) begin
            pp_ff[i] <= PROD_W'(a[ADJ_TAB[i][0]]) * PROD_W'(a[ADJ_TAB[i][1]]);
            pn_ff[i] <= PROD_W'(a[ADJ_TAB[i][2]]) * PROD_W'(a[ADJ_TAB[i][3]]);
            adj2_ff[i] <= ADJ_W'(pp_ff[i]) - ADJ_W'(pn_ff[i]);
            adj3_ff[i] <= adj2_ff[i];
            adj4_ff[i] <= adj3_ff[i];
         end
         for (int k = 0; k < 3; k++) begin
            col1_ff[k] <= a[3*k];
            col2_ff[k] <= col1_ff[k];
            dlo_ff[k]  <= DP_W'(col2_ff[k]) * DP_W'($signed({1'b0, adj2_ff[k][31:0]}));
            dhi_ff[k]  <= DP_W'(col2_ff[k]) * DP_W'($signed(adj2_ff[k][ADJ_W-1:32]));
         end
         det_ff <= (DET_W'(dhi_ff[0]) <<< 32) + DET_W'(dlo_ff[0])
                 + (DET_W'(dhi_ff[1]) <<< 32) + DET_W'(dlo_ff[1])
                 + (DET_W'(dhi_ff[2]) <<< 32) + DET_W'(dlo_ff[2]);
      end
   end

   logic [DET_W-1:0]   det_mag;
   logic [ADJ_W-1:0]   adj_mag [9];

   always_comb begin
      det_mag = det_ff[DET_W-1] ? DET_W'(-det_ff) : DET_W'(det_ff);
      for (int i = 0; i < 9; i++) begin
         adj_mag[i] = adj4_ff[i][ADJ_W-1] ? ADJ_W'(-adj4_ff[i]) : ADJ_W'(adj4_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 9; i++) begin
            num_ff[i] <= NUM_W'(adj_mag[i][PROD_W-1:0]) << (2 * FRAC_BITS);
            neg_ff[i] <= adj4_ff[i][ADJ_W-1] ^ det_ff[DET_W-1];
         end
         num_ff[9] <= NUM_W'(1) << (4 * FRAC_BITS);
         neg_ff[9] <= det_ff[DET_W-1];
         den_ff    <= det_mag[DEN_W-1:0];
         sing5_ff  <= (det_ff == '0);
      end
   end

   logic signed [ENTRY_W-1:0] quot [10];
   logic [9:0]                sat;

   for (genvar i = 0; i < 10; i++) begin : g_div
      mi3_div #(.NUM_W(NUM_W)) u_div (
         .clock  (clock),
         .enable (adv),
         .num    (num_ff[i]),
         .den    (den_ff),
         .neg    (neg_ff[i]),
         .quot   (quot[i]),
         .sat    (sat[i])
      );
   end

   logic [DLY-1:0] vd_ff;
   logic [DLY-1:0] sing_ff;
   logic           rsp_valid_ff;
   rsp_type        rsp_data_ff;
   rsp_type        rsp_data_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         vd_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v_ff         <= {v_ff[3:0], req_valid};
         vd_ff        <= {vd_ff[DLY-2:0], v_ff[4]};
         rsp_valid_ff <= vd_ff[DLY-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sing_ff     <= {sing_ff[DLY-2:0], sing5_ff};
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_comb begin
      rsp_data_in.inv_00    = quot[0];
      rsp_data_in.inv_01    = quot[1];
      rsp_data_in.inv_02    = quot[2];
      rsp_data_in.inv_10    = quot[3];
      rsp_data_in.inv_11    = quot[4];
      rsp_data_in.inv_12    = quot[5];
      rsp_data_in.inv_20    = quot[6];
      rsp_data_in.inv_21    = quot[7];
      rsp_data_in.inv_22    = quot[8];
      rsp_data_in.recip_det = quot[9];
      rsp_data_in.singular  = sing_ff[DLY-1];
      rsp_data_in.saturated = |sat;
      if (sing_ff[DLY-1]) begin
         rsp_data_in           = '0;
         rsp_data_in.singular  = 1'b1;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* hdl/mi3_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_chk
// Port-level checks for the 3x3 matrix inverse.
// ----------------------------------------------------------------------------
module mi3_chk
   import mi3_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // held response stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // input stalls only behind a stalled response
   a_stall_src: assert property (@(posedge clock)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled with free output");

   // nothing pending after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // singular transaction carries zeros
   a_singular: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.singular |->
         rsp_data.inv_00 == 0 && rsp_data.inv_11 == 0 && rsp_data.inv_22 == 0 &&
         rsp_data.recip_det == 0 && !rsp_data.saturated)
      else $error("singular transaction with nonzero result");

   // singular transaction has zero inv_01 and inv_10 entries
   a_recip: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.singular |-> rsp_data.inv_01 == 0 && rsp_data.inv_10 == 0)
      else $error("singular transaction with nonzero off-diagonal");

endmodule

bind matrix_inverse_3x3 mi3_chk u_mi3_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
